// ===== rtl/csvfp_pkg.sv =====
package csvfp_pkg;

	// special bytes of the csv text
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// input op codes
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_EOF  = 1'b1;

	// result kinds
	typedef enum logic [1:0] {
		KIND_BYTE      = 2'd0,
		KIND_FIELD_END = 2'd1,
		KIND_ROW_END   = 2'd2,
		KIND_FILE_END  = 2'd3
	} kind_t;

	// saturation limits of the result fields
	localparam int COL_SAT    = 255;
	localparam int ROW_SAT    = 65535;
	localparam int LEN_SAT    = 255;
	localparam int WIDEST_SAT = 511;

	// most results one input beat can cause
	localparam int MAX_RES = 3;

	// result queue
	localparam int QDEPTH = 8;
	localparam int QAW    = 3;
	localparam int QCW    = 4;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [7:0]  column_index;
		logic [15:0] row_index;
		logic [7:0]  field_length;
		logic [8:0]  widest_row;
		logic        last;
	} entry_t;

endpackage

// ===== rtl/csv_field_parser_unit.sv =====
// a taken input beat waits in the input stage, then its results are written to the result queue
// throughput: one input beat per cycle unless in_stall holds it; each input beat yields zero to three
// result beats, delivered one per cycle while out_stall is low through an eight-entry result queue,
// so the output port sets the sustained rate when items yield several beats
// reset: arst_n clears parser state, counters, input stage and queue at once
module csv_field_parser_unit
	import csvfp_pkg::*;
#(
	parameter int MAX_FIELD_BYTES = 255,
	parameter int MAX_COLUMNS     = 256,
	parameter int ROW_LIMIT       = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [7:0]  column_index,
	output logic [15:0] row_index,
	output logic [7:0]  field_length,
	output logic [8:0]  widest_row,
	output logic        last
);

	localparam int FW = $clog2(MAX_FIELD_BYTES + 1);
	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam int RW = $clog2(ROW_LIMIT + 1);

	typedef enum logic [2:0] {
		ST_START  = 3'd0,
		ST_PLAIN  = 3'd1,
		ST_QUOTED = 3'd2,
		ST_QSEEN  = 3'd3,
		ST_SKIP   = 3'd4
	} pstate_t;

	// input stage
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;

	// parser state
	pstate_t       st_q;
	logic [FW-1:0] fc_q;
	logic [CW-1:0] cc_q;
	logic [RW-1:0] rc_q;
	logic [CW-1:0] wc_q;
	logic          ro_q;

	// next state and results of the beat in the input stage
	pstate_t       st_d;
	logic [FW-1:0] fc_d;
	logic [CW-1:0] cc_d;
	logic [RW-1:0] rc_d;
	logic [CW-1:0] wc_d;
	logic          ro_d;
	entry_t        res [MAX_RES];
	logic [1:0]    res_n;

	// result queue
	entry_t         q_mem [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QCW-1:0] cnt_q;

	logic adv;
	logic pop;

	function automatic entry_t make_entry(kind_t k, logic [7:0] b, logic [CW-1:0] cc,
			logic [RW-1:0] rc, logic [FW-1:0] fc, logic [CW-1:0] wc);
		entry_t e;
		e.kind         = k;
		e.out_byte     = b;
		e.column_index = (32'(cc) > COL_SAT) ? 8'(COL_SAT) : 8'(cc);
		e.row_index    = (32'(rc) > ROW_SAT) ? 16'(ROW_SAT) : 16'(rc);
		e.field_length = (32'(fc) > LEN_SAT) ? 8'(LEN_SAT) : 8'(fc);
		e.widest_row   = (32'(wc) > WIDEST_SAT) ? 9'(WIDEST_SAT) : 9'(wc);
		e.last         = 1'b0;
		return e;
	endfunction

	// the beat moves on once the queue has room for a full burst
	assign adv      = valid_s1 && (cnt_q <= QCW'(QDEPTH - MAX_RES));
	assign in_stall = valid_s1 && !adv;
	assign pop      = out_valid && !out_stall;

	// parse one beat: choose the events, then run them in their fixed order
	always_comb begin
		logic put_a;
		logic put_b;
		logic do_fe;
		logic do_re;
		logic do_file;
		put_a   = 1'b0;
		put_b   = 1'b0;
		do_fe   = 1'b0;
		do_re   = 1'b0;
		do_file = 1'b0;
		st_d    = st_q;
		fc_d    = fc_q;
		cc_d    = cc_q;
		rc_d    = rc_q;
		wc_d    = wc_q;
		ro_d    = ro_q;
		res_n   = 2'd0;
		for (int i = 0; i < MAX_RES; i++) begin
			res[i] = '0;
		end

		if (op_s1 == OP_EOF) begin
			do_fe   = ro_q && (st_q == ST_PLAIN || st_q == ST_QUOTED || st_q == ST_QSEEN);
			do_re   = ro_q;
			do_file = 1'b1;
		end else begin
			ro_d = 1'b1;
			case (st_q)
				ST_PLAIN: begin
					if (byte_s1 == CH_COMMA) begin
						do_fe = 1'b1;
						st_d  = ST_START;
					end else if (byte_s1 == CH_LF) begin
						do_fe = 1'b1;
						do_re = 1'b1;
					end else if (byte_s1 == CH_CR) begin
						do_fe = 1'b1;
						st_d  = ST_SKIP;
					end else begin
						put_b = 1'b1;
					end
				end
				ST_QUOTED: begin
					if (byte_s1 == CH_QUOTE) begin
						st_d = ST_QSEEN;
					end else if (byte_s1 == CH_LF) begin
						put_a = 1'b1;
						do_fe = 1'b1;
						do_re = 1'b1;
					end else begin
						put_b = 1'b1;
					end
				end
				ST_QSEEN: begin
					if (byte_s1 == CH_QUOTE) begin
						put_b = 1'b1;
						st_d  = ST_QUOTED;
					end else if (byte_s1 == CH_COMMA) begin
						do_fe = 1'b1;
						st_d  = ST_START;
					end else if (byte_s1 == CH_LF) begin
						do_fe = 1'b1;
						do_re = 1'b1;
					end else if (byte_s1 == CH_CR) begin
						do_fe = 1'b1;
						st_d  = ST_SKIP;
					end else begin
						do_fe = 1'b1;
						put_b = 1'b1;
						st_d  = ST_PLAIN;
					end
				end
				ST_SKIP: begin
					do_re = (byte_s1 == CH_LF);
				end
				default: begin
					if (byte_s1 == CH_LF) begin
						do_re = 1'b1;
					end else if (byte_s1 == CH_CR) begin
						st_d = ST_SKIP;
					end else if (byte_s1 == CH_COMMA) begin
						do_fe = 1'b1;
						st_d  = ST_START;
					end else if (byte_s1 == CH_QUOTE) begin
						st_d = ST_QUOTED;
					end else begin
						put_b = 1'b1;
						st_d  = ST_PLAIN;
					end
				end
			endcase
		end

		// content byte ahead of the field end (line feed inside quotes)
		if (put_a && (32'(fc_d) < MAX_FIELD_BYTES)) begin
			fc_d       = fc_d + FW'(1);
			res[res_n] = make_entry(KIND_BYTE, byte_s1, cc_d, rc_d, '0, wc_d);
			res_n      = res_n + 2'd1;
		end

		// field end
		if (do_fe) begin
			res[res_n] = make_entry(KIND_FIELD_END, 8'h00, cc_d, rc_d, fc_d, wc_d);
			res_n      = res_n + 2'd1;
			fc_d       = '0;
			if (32'(cc_d) < MAX_COLUMNS) begin
				cc_d = cc_d + CW'(1);
			end
		end

		// ordinary content byte
		if (put_b && (32'(fc_d) < MAX_FIELD_BYTES)) begin
			fc_d       = fc_d + FW'(1);
			res[res_n] = make_entry(KIND_BYTE, byte_s1, cc_d, rc_d, '0, wc_d);
			res_n      = res_n + 2'd1;
		end

		// row end
		if (do_re) begin
			if (cc_d > wc_d) begin
				wc_d = cc_d;
			end
			res[res_n] = make_entry(KIND_ROW_END, 8'h00, cc_d, rc_d, '0, wc_d);
			res_n      = res_n + 2'd1;
			if (32'(rc_d) < ROW_LIMIT) begin
				rc_d = rc_d + RW'(1);
			end
			cc_d = '0;
			fc_d = '0;
			ro_d = 1'b0;
			st_d = ST_START;
		end

		// file end, then back to the reset state
		if (do_file) begin
			res[res_n] = make_entry(KIND_FILE_END, 8'h00, '0, rc_d, '0, wc_d);
			res_n      = res_n + 2'd1;
			st_d       = ST_START;
			fc_d       = '0;
			cc_d       = '0;
			rc_d       = '0;
			wc_d       = '0;
			ro_d       = 1'b0;
		end

		// mark the last result of the beat
		for (int i = 0; i < MAX_RES; i++) begin
			res[i].last = (3'(i) + 3'd1 == {1'b0, res_n});
		end
	end

	// input stage and parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= ST_START;
			fc_q     <= '0;
			cc_q     <= '0;
			rc_q     <= '0;
			wc_q     <= '0;
			ro_q     <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				st_q <= st_d;
				fc_q <= fc_d;
				cc_q <= cc_d;
				rc_q <= rc_d;
				wc_q <= wc_d;
				ro_q <= ro_d;
			end
		end
	end

	// input payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op;
			byte_s1 <= in_byte;
		end
	end

	// queue storage, up to three writes per cycle
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < MAX_RES; i++) begin
				if (2'(i) < res_n) begin
					q_mem[wr_q + QAW'(i)] <= res[i];
				end
			end
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (adv) begin
				wr_q <= wr_q + QAW'(res_n);
			end
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			cnt_q <= cnt_q + (adv ? QCW'(res_n) : QCW'(0)) - (pop ? QCW'(1) : QCW'(0));
		end
	end

	// result port
	assign out_valid    = (cnt_q != '0);
	assign kind         = q_mem[rd_q].kind;
	assign out_byte     = q_mem[rd_q].out_byte;
	assign column_index = q_mem[rd_q].column_index;
	assign row_index    = q_mem[rd_q].row_index;
	assign field_length = q_mem[rd_q].field_length;
	assign widest_row   = q_mem[rd_q].widest_row;
	assign last         = q_mem[rd_q].last;

`ifndef NO_ASSERTIONS
	// queue never overfills
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCW'(QDEPTH))
		else $error("result queue overfilled");

	// a file end always closes the burst of its beat
	a_file_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FILE_END |-> last)
		else $error("file end not marked last");

	// end of input leaves the parser in its reset state
	a_eof_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_s1 == OP_EOF |=> st_q == ST_START && rc_q == '0 && cc_q == '0 && !ro_q)
		else $error("state not cleared after end of input");

	// length only on field ends, content byte only on field bytes
	a_field_zeros: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_FIELD_END && kind != KIND_BYTE |->
			field_length == 8'h00 && out_byte == 8'h00)
		else $error("nonzero payload on row or file end");
`endif

endmodule

// ===== sim/csv_field_parser_unit_tb.sv =====
`timescale 1ns / 100ps

module csv_field_parser_unit_tb;
	import csvfp_pkg::*;

	localparam int MAX_FIELD_BYTES = 255;
	localparam int MAX_COLUMNS     = 256;
	localparam int ROW_LIMIT       = 65536;
	localparam int HOLDOFF_CYCLES  = 300;
	localparam int QUIET_LIMIT     = 2000;
	localparam int TAIL_CYCLES     = 8;

	typedef enum logic [2:0] {
		PS_START,
		PS_PLAIN,
		PS_QUOTED,
		PS_QSEEN,
		PS_SKIP
	} parse_state_t;

	typedef enum int {
		RUN_FREE,
		RUN_BLOCK,
		RUN_COIN
	} stall_run_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = OP_DATA;
	logic [7:0]  in_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [7:0]  column_index;
	logic [15:0] row_index;
	logic [7:0]  field_length;
	logic [8:0]  widest_row;
	logic        last;

	// parser state mirrored by the testbench
	parse_state_t ps;
	int           fld_len;
	int           col_cnt;
	int           row_cnt;
	int           widest;
	bit           row_open;

	// tokens produced by one beat, then the queue of tokens still owed by the block
	entry_t step_buf [MAX_RES];
	int     step_n;
	entry_t pending_tokens [$];
	entry_t want_tok;

	int mismatches = 0;
	int beats_sent = 0;
	int burst_left = 0;
	int gap_len;
	bit send_idle = 1'b0;
	bit recv_idle = 1'b0;
	int holdoff_req = 0;
	int holdoff_seen = 0;
	int holdoff_left = 0;
	int stall_left = 0;
	stall_run_t stall_style = RUN_FREE;
	int quiet_cycles = 0;

	csv_field_parser_unit #(
		.MAX_FIELD_BYTES(MAX_FIELD_BYTES),
		.MAX_COLUMNS(MAX_COLUMNS),
		.ROW_LIMIT(ROW_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.out_byte(out_byte),
		.column_index(column_index),
		.row_index(row_index),
		.field_length(field_length),
		.widest_row(widest_row),
		.last(last)
	);

	always #1 clk = ~clk;

	function automatic int clip(int v, int lim);
		return (v > lim) ? lim : v;
	endfunction

	// append one token to this beat's output, at most three per beat
	function automatic void token_out(kind_t k, logic [7:0] b, int col, int row, int len);
		entry_t t;
		if (step_n >= MAX_RES)
			return;
		t.kind = k;
		t.out_byte = b;
		t.column_index = 8'(clip(col, COL_SAT));
		t.row_index = 16'(clip(row, ROW_SAT));
		t.field_length = 8'(clip(len, LEN_SAT));
		t.widest_row = 9'(clip(widest, WIDEST_SAT));
		t.last = 1'b0;
		step_buf[step_n] = t;
		step_n++;
	endfunction

	// content byte, dropped once the field is full
	function automatic void store_byte(logic [7:0] b);
		if (fld_len >= MAX_FIELD_BYTES)
			return;
		fld_len++;
		token_out(KIND_BYTE, b, col_cnt, row_cnt, 0);
	endfunction

	function automatic void close_field();
		token_out(KIND_FIELD_END, 8'h00, col_cnt, row_cnt, fld_len);
		fld_len = 0;
		if (col_cnt < MAX_COLUMNS)
			col_cnt++;
	endfunction

	function automatic void close_row();
		if (col_cnt > widest)
			widest = col_cnt;
		token_out(KIND_ROW_END, 8'h00, col_cnt, row_cnt, 0);
		if (row_cnt < ROW_LIMIT)
			row_cnt++;
		col_cnt = 0;
		fld_len = 0;
		row_open = 1'b0;
		ps = PS_START;
	endfunction

	function automatic void new_file();
		ps = PS_START;
		fld_len = 0;
		col_cnt = 0;
		row_cnt = 0;
		widest = 0;
		row_open = 1'b0;
	endfunction

	// tokens the block owes for one accepted beat
	function automatic void parse_csv_beat(logic o, logic [7:0] b);
		step_n = 0;
		if (o == OP_EOF) begin
			if (row_open) begin
				if (ps == PS_PLAIN || ps == PS_QUOTED || ps == PS_QSEEN)
					close_field();
				close_row();
			end
			token_out(KIND_FILE_END, 8'h00, 0, row_cnt, 0);
			new_file();
		end else begin
			row_open = 1'b1;
			case (ps)
				PS_PLAIN: begin
					if (b == CH_COMMA) begin
						close_field();
						ps = PS_START;
					end else if (b == CH_LF) begin
						close_field();
						close_row();
					end else if (b == CH_CR) begin
						close_field();
						ps = PS_SKIP;
					end else begin
						store_byte(b);
					end
				end
				PS_QUOTED: begin
					if (b == CH_QUOTE) begin
						ps = PS_QSEEN;
					end else if (b == CH_LF) begin
						store_byte(b);
						close_field();
						close_row();
					end else begin
						store_byte(b);
					end
				end
				PS_QSEEN: begin
					if (b == CH_QUOTE) begin
						store_byte(b);
						ps = PS_QUOTED;
					end else if (b == CH_COMMA) begin
						close_field();
						ps = PS_START;
					end else if (b == CH_LF) begin
						close_field();
						close_row();
					end else if (b == CH_CR) begin
						close_field();
						ps = PS_SKIP;
					end else begin
						close_field();
						store_byte(b);
						ps = PS_PLAIN;
					end
				end
				PS_SKIP: begin
					if (b == CH_LF)
						close_row();
				end
				default: begin
					if (b == CH_LF) begin
						close_row();
					end else if (b == CH_CR) begin
						ps = PS_SKIP;
					end else if (b == CH_COMMA) begin
						close_field();
						ps = PS_START;
					end else if (b == CH_QUOTE) begin
						ps = PS_QUOTED;
					end else begin
						store_byte(b);
						ps = PS_PLAIN;
					end
				end
			endcase
		end
		if (step_n > 0)
			step_buf[step_n - 1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			pending_tokens.push_back(step_buf[i]);
	endfunction

	// random text byte; plain fields never get separators, quoted ones rarely a line feed
	function automatic logic [7:0] pick_text(bit quoted);
		logic [7:0] b;
		case ($urandom_range(0, 19))
			0, 1, 2: b = 8'($urandom_range(0, 255));
			3: b = CH_QUOTE;
			4: b = CH_COMMA;
			5: b = CH_CR;
			6: b = CH_LF;
			default: b = 8'($urandom_range(32, 126));
		endcase
		if (!quoted && (b == CH_COMMA || b == CH_CR || b == CH_LF))
			b = b ^ 8'h40;
		if (quoted && b == CH_LF && $urandom_range(0, 3) != 0)
			b = b ^ 8'h40;
		return b;
	endfunction

	// offer one beat, hold it until taken, then predict its tokens
	task automatic send_beat(input logic o, input logic [7:0] b);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap_len = send_idle ? $urandom_range(0, 6) : 0;
			if (gap_len > 0) begin
				in_valid <= 1'b0;
				repeat (gap_len) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		op <= o;
		in_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
		parse_csv_beat(o, b);
	endtask

	task automatic send_char(input logic [7:0] b);
		send_beat(OP_DATA, b);
	endtask

	// quote inside a quoted field goes out doubled
	task automatic send_quoted_content(input logic [7:0] b);
		send_char(b);
		if (b == CH_QUOTE)
			send_char(b);
	endtask

	task automatic send_random_field();
		int len;
		len = $urandom_range(0, 6);
		if ($urandom_range(0, 2) == 0) begin
			send_char(CH_QUOTE);
			repeat (len) send_quoted_content(pick_text(1'b1));
			send_char(CH_QUOTE);
			// stray text right after the closing quote
			if ($urandom_range(0, 7) == 0)
				send_char(pick_text(1'b0));
		end else begin
			repeat (len) send_char(pick_text(1'b0));
		end
	endtask

	// stop offering and wait for every owed token
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_tokens.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_idle = 1'b0;
		recv_idle <= 1'b0;
		// plain field with zero and all-ones content
		send_char("a");
		send_char(8'h00);
		send_char(8'hFF);
		send_char(CH_COMMA);
		// doubled quote, then text right after the closing quote
		send_char(CH_QUOTE);
		send_char("x");
		send_char(CH_QUOTE);
		send_char(CH_QUOTE);
		send_char(CH_QUOTE);
		send_char("z");
		// empty field, then trailing comma before line feed
		send_char(CH_COMMA);
		send_char(CH_COMMA);
		send_char(CH_LF);
		// empty line
		send_char(CH_LF);
		// cr as quoted content, line feed inside quotes ends field and row
		send_char(CH_QUOTE);
		send_char(CH_CR);
		send_char(CH_LF);
		// cr ends the field, the rest of the line is skipped
		send_char("b");
		send_char(CH_CR);
		send_char(CH_QUOTE);
		send_char(CH_LF);
		// trailing comma at end of input, then an empty file
		send_char(CH_COMMA);
		send_beat(OP_EOF, 8'h00);
		send_beat(OP_EOF, 8'hFF);
		// end of input inside an open quoted field
		send_char(CH_QUOTE);
		send_char("q");
		send_beat(OP_EOF, 8'h5A);
		drain();
	endtask

	task automatic test_long_field();
		send_idle = 1'b1;
		recv_idle <= 1'b1;
		repeat (MAX_FIELD_BYTES + 4) send_char(pick_text(1'b0));
		send_char(CH_COMMA);
		send_char(CH_QUOTE);
		repeat (MAX_FIELD_BYTES + 2) send_quoted_content(pick_text(1'b1));
		send_char(CH_QUOTE);
		send_char(CH_LF);
		send_beat(OP_EOF, 8'h00);
		drain();
	endtask

	// more fields than MAX_COLUMNS, where the column counter saturates
	task automatic test_wide_row();
		send_idle = 1'b0;
		recv_idle <= 1'b1;
		repeat (MAX_COLUMNS + 2) send_char(CH_COMMA);
		send_char("w");
		send_char(CH_LF);
		send_char("v");
		send_char(CH_LF);
		send_beat(OP_EOF, 8'h00);
		drain();
	endtask

	// receiver holds off long enough for the result queue to fill
	task automatic test_backpressure();
		send_idle = 1'b0;
		recv_idle <= 1'b0;
		holdoff_req <= holdoff_req + 1;
		send_char(CH_QUOTE);
		repeat (40) send_quoted_content(pick_text(1'b1));
		send_char(CH_QUOTE);
		repeat (6) begin
			send_random_field();
			send_char(CH_COMMA);
		end
		send_char(CH_LF);
		drain();
	endtask

	// mostly well-formed rows with random content, some raw noise
	task automatic test_random_files(input int target);
		int start_cnt;
		int nf;
		start_cnt = beats_sent;
		while (beats_sent - start_cnt < target) begin
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle <= ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 8))
					send_beat(($urandom_range(0, 15) == 0) ? OP_EOF : OP_DATA,
						8'($urandom));
			end else begin
				nf = $urandom_range(0, 5);
				for (int i = 0; i < nf; i++) begin
					if (i > 0)
						send_char(CH_COMMA);
					send_random_field();
				end
				// line ending: plain, trailing comma, or cr with junk up to the lf
				case ($urandom_range(0, 7))
					0: begin
						send_char(CH_COMMA);
						send_char(CH_LF);
					end
					1: begin
						send_char(CH_CR);
						repeat ($urandom_range(0, 2)) send_char(pick_text(1'b1));
						send_char(CH_LF);
					end
					default: send_char(CH_LF);
				endcase
			end
			if ($urandom_range(0, 7) == 0)
				send_beat(OP_EOF, 8'($urandom));
		end
		send_beat(OP_EOF, 8'($urandom));
		drain();
	endtask

	// receiver stall pattern: runs of free, blocked or coin-toss cycles
	always @(posedge clk) begin
		if (holdoff_seen != holdoff_req) begin
			holdoff_seen = holdoff_req;
			holdoff_left = HOLDOFF_CYCLES;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_stall <= 1'b1;
		end else if (!recv_idle) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_left = $urandom_range(1, 20);
				stall_style = stall_run_t'($urandom_range(0, 2));
			end
			stall_left--;
			case (stall_style)
				RUN_FREE: out_stall <= 1'b0;
				RUN_BLOCK: out_stall <= 1'b1;
				default: out_stall <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// compare every accepted result beat with the oldest owed token
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tokens.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual kind %0d byte %0d",
					$time, kind, out_byte);
			end else begin
				want_tok = pending_tokens.pop_front();
				check_field("kind", want_tok.kind, kind);
				check_field("out_byte", want_tok.out_byte, out_byte);
				check_field("column_index", want_tok.column_index, column_index);
				check_field("row_index", want_tok.row_index, row_index);
				check_field("field_length", want_tok.field_length, field_length);
				check_field("widest_row", want_tok.widest_row, widest_row);
				check_field("last", want_tok.last, last);
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		new_file();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_files(230);
		test_backpressure();
		test_long_field();
		test_wide_row();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/csvfp_pkg.sv
rtl/csv_field_parser_unit.sv
sim/csv_field_parser_unit_tb.sv
